// ===== hw/rtl/bis_pkg.sv =====
// Shared types, constants and helper functions of the bilinear image scaler.
// No dependencies; every other RTL file refers to it by scoped names.
`default_nettype none

package bis_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int PIX_W    = 8;
    localparam int COORD_W  = 13;
    localparam int DIM_W    = 11;
    localparam int SCALE_W  = 16;
    localparam int SC_W     = 11;   // clamped scale, at most 1280
    localparam int STEP_W   = 19;   // floor(2^24 / 51) fits
    localparam int POS_W    = COORD_W + STEP_W;
    localparam int FRAC_W   = 8;
    localparam int WT_W     = 17;   // weight product, at most 65536
    localparam int ACC_W    = 24;
    localparam int OUTD_W   = 2 * SC_W - FRAC_W;  // output width / height
    localparam int AREA_W   = 2 * DIM_W - 1;

    localparam int SCALE_MIN  = 51;
    localparam int SCALE_MAX  = 1280;
    localparam int ROW_BORDER = 3;
    localparam int RECIP_BITS = 25;   // dividend 2^24 has 25 bits
    localparam int RCNT_W     = $clog2(RECIP_BITS);
    localparam int STEP_RESET = 65536;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q8      = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [PIX_W-1:0]   pixel_in;
        logic [COORD_W-1:0] out_column;
        logic [COORD_W-1:0] out_row;
    } bis_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] gray_out;
        logic             out_of_range;
    } bis_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_BASE,
        ST_READ,
        ST_DRAIN,
        ST_EMIT
    } bis_state_t;

    typedef struct packed {
        logic       capture;
        logic       load_we;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       acc_clear;
        logic       out_load;
    } bis_cmd_t;

    typedef struct packed {
        logic oor;
        logic out_busy;
    } bis_status_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] limit);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > limit)
            r = limit;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [SC_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
        logic [SC_W-1:0] r;
        if (v < SCALE_W'(SCALE_MIN))
            r = SC_W'(SCALE_MIN);
        else if (v > SCALE_W'(SCALE_MAX))
            r = SC_W'(SCALE_MAX);
        else
            r = v[SC_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bis_frame_store.sv =====
// Single-port source frame memory with registered read data.
// Depends on bis_pkg for depth, address and pixel widths.
`default_nettype none

module bis_frame_store (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [bis_pkg::ADDR_W-1:0] addr,
    input  wire logic [bis_pkg::PIX_W-1:0]  wdata,
    output logic      [bis_pkg::PIX_W-1:0]  rdata
);

    logic [bis_pkg::PIX_W-1:0] mem [bis_pkg::STORE_DEPTH];
    logic [bis_pkg::PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        else if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bis_recip.sv =====
// Restoring divider producing step = floor(2^24 / scale), one quotient bit a cycle.
// Depends on bis_pkg for widths and the reset step.
`default_nettype none

module bis_recip (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [bis_pkg::SC_W-1:0] divisor,
    output logic                          busy,
    output logic [bis_pkg::STEP_W-1:0]    step
);

    logic                          busy_reg, busy_next;
    logic [bis_pkg::RCNT_W-1:0]    cnt_reg, cnt_next;
    logic [bis_pkg::SC_W-1:0]      rem_reg, rem_next;
    logic [bis_pkg::SC_W-1:0]      div_reg, div_next;
    logic [bis_pkg::STEP_W-1:0]    quo_reg, quo_next;
    logic [bis_pkg::SC_W:0]        trial;
    logic [bis_pkg::SC_W:0]        diff;
    logic                          ge;

    // dividend is a single one at bit 24
    assign trial = {rem_reg, (cnt_reg == bis_pkg::RCNT_W'(bis_pkg::RECIP_BITS - 1))};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = bis_pkg::RCNT_W'(bis_pkg::RECIP_BITS - 1);
            rem_next  = '0;
            div_next  = divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[bis_pkg::SC_W-1:0] : trial[bis_pkg::SC_W-1:0];
            quo_next = {quo_reg[bis_pkg::STEP_W-2:0], ge};
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            div_reg  <= '0;
            quo_reg  <= bis_pkg::STEP_W'(bis_pkg::STEP_RESET);
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            div_reg  <= div_next;
            quo_reg  <= quo_next;
        end
    end

    assign busy = busy_reg;
    assign step = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bis_datapath.sv =====
// Datapath: load address counter, position and weight arithmetic, neighbour
// address generation, accumulator and output register. Uses bis_pkg, bis_frame_store.
`default_nettype none

module bis_datapath (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire bis_pkg::bis_in_t           in_data,
    input  wire bis_pkg::bis_cmd_t          cmd,
    input  wire logic [bis_pkg::DIM_W-1:0]  eff_width,
    input  wire logic [bis_pkg::DIM_W-1:0]  eff_height,
    input  wire logic [bis_pkg::SC_W-1:0]   eff_scale,
    input  wire logic [bis_pkg::STEP_W-1:0] step,
    output bis_pkg::bis_status_t            status,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output bis_pkg::bis_out_t               out_data
);

    localparam int AW = bis_pkg::ADDR_W;
    localparam int PW = bis_pkg::POS_W;

    logic [AW-1:0]                   load_addr_reg, load_addr_next;
    logic [bis_pkg::AREA_W-1:0]      area;
    logic [AW:0]                     addr_inc;

    logic [bis_pkg::COORD_W-1:0]     col_reg, row_reg;
    logic [PW-1:0]                   px_reg, py_reg;
    logic [bis_pkg::OUTD_W-1:0]      outw_reg, outh_reg;
    logic [2*bis_pkg::SC_W-1:0]      outw_full, outh_full;

    logic [AW-1:0]                   base_reg;
    logic [bis_pkg::WT_W-1:0]        wa_reg, wb_reg, wc_reg, wd_reg;
    logic [bis_pkg::FRAC_W-1:0]      fx, fy;
    logic [bis_pkg::FRAC_W:0]        gx, gy;
    logic [PW-17+bis_pkg::DIM_W:0]   yw;

    logic [AW-1:0]                   w_ext;
    logic [AW-1:0]                   rd_addr;
    logic [AW-1:0]                   mem_addr;
    logic [bis_pkg::PIX_W-1:0]       rdata;

    logic                            pend_reg;
    logic [1:0]                      psel_reg;
    logic [bis_pkg::WT_W-1:0]        wsel;
    logic [bis_pkg::PIX_W+bis_pkg::WT_W-1:0] prod;
    logic [bis_pkg::ACC_W-1:0]       acc_reg, acc_next;

    logic                            oor;
    logic                            out_valid_reg;
    bis_pkg::bis_out_t               out_data_reg;

    // load address counter, wraps at width*height
    assign area     = bis_pkg::AREA_W'(eff_width * eff_height);
    assign addr_inc = {1'b0, load_addr_reg} + 1'b1;

    always_comb
    begin
        if (bis_pkg::AREA_W'(addr_inc) >= area)
            load_addr_next = '0;
        else
            load_addr_next = addr_inc[AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_addr_reg <= '0;
        else if (cmd.load_we)
            load_addr_reg <= load_addr_next;
    end

    // query coordinates
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_reg <= in_data.out_column;
            row_reg <= in_data.out_row;
        end
    end

    // stage 1: source positions and output extent
    assign outw_full = eff_width * eff_scale;
    assign outh_full = eff_height * eff_scale;

    always_ff @(posedge clk)
    begin
        px_reg   <= PW'(col_reg * step);
        py_reg   <= PW'(row_reg * step);
        outw_reg <= outw_full[2*bis_pkg::SC_W-1:bis_pkg::FRAC_W];
        outh_reg <= outh_full[2*bis_pkg::SC_W-1:bis_pkg::FRAC_W];
    end

    // stage 2: flat base address and the four weights
    assign fx = px_reg[15:8];
    assign fy = py_reg[15:8];
    assign gx = 9'd256 - {1'b0, fx};
    assign gy = 9'd256 - {1'b0, fy};
    assign yw = py_reg[PW-1:16] * eff_width;

    always_ff @(posedge clk)
    begin
        base_reg <= AW'(yw) + AW'(px_reg[PW-1:16]);
        wa_reg   <= bis_pkg::WT_W'(gx * gy);
        wb_reg   <= bis_pkg::WT_W'(fx * gy);
        wc_reg   <= bis_pkg::WT_W'(fy * gx);
        wd_reg   <= bis_pkg::WT_W'(fx * fy);
    end

    assign oor = ({1'b0, col_reg} >= outw_reg)
               || (({1'b0, row_reg} + bis_pkg::OUTD_W'(bis_pkg::ROW_BORDER)) >= outh_reg);

    // neighbour addresses, wrapping over the store
    assign w_ext = AW'(eff_width);

    always_comb
    begin
        case (cmd.rd_sel)
            2'd0:    rd_addr = base_reg;
            2'd1:    rd_addr = base_reg + 1'b1;
            2'd2:    rd_addr = base_reg + w_ext;
            2'd3:    rd_addr = base_reg + w_ext + 1'b1;
            default: rd_addr = base_reg;
        endcase
    end

    assign mem_addr = cmd.load_we ? load_addr_reg : rd_addr;

    bis_frame_store u_store (
        .clk   (clk),
        .we    (cmd.load_we),
        .re    (cmd.rd_en),
        .addr  (mem_addr),
        .wdata (in_data.pixel_in),
        .rdata (rdata)
    );

    // weighted accumulation, one neighbour a cycle
    always_comb
    begin
        case (psel_reg)
            2'd0:    wsel = wa_reg;
            2'd1:    wsel = wb_reg;
            2'd2:    wsel = wc_reg;
            2'd3:    wsel = wd_reg;
            default: wsel = wa_reg;
        endcase
    end

    assign prod = rdata * wsel;

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_clear)
            acc_next = '0;
        else if (pend_reg)
            acc_next = acc_reg + prod[bis_pkg::ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            psel_reg <= '0;
        end
        else
        begin
            pend_reg <= cmd.rd_en;
            psel_reg <= cmd.rd_sel;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg.gray_out     <= oor ? '0 : acc_reg[bis_pkg::ACC_W-1:16];
            out_data_reg.out_of_range <= oor;
        end
    end

    assign status.oor      = oor;
    assign status.out_busy = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/bis_ctrl.sv =====
// Controller state machine sequencing a query through the datapath.
// Depends on bis_pkg for the state, command and status types.
`default_nettype none

module bis_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 operation,
    input  wire logic                 step_busy,
    input  wire bis_pkg::bis_status_t status,
    output logic                      in_stall,
    output bis_pkg::bis_cmd_t         cmd
);

    bis_pkg::bis_state_t state_reg, state_next;
    logic [1:0]          rd_cnt_reg, rd_cnt_next;
    logic                accept;

    assign in_stall = (state_reg != bis_pkg::ST_IDLE) || step_busy;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = '0;
        case (state_reg)
            bis_pkg::ST_IDLE:
            begin
                if (accept && operation == bis_pkg::OP_QUERY)
                    state_next = bis_pkg::ST_MUL;
            end
            bis_pkg::ST_MUL:
                state_next = bis_pkg::ST_BASE;
            bis_pkg::ST_BASE:
                state_next = status.oor ? bis_pkg::ST_EMIT : bis_pkg::ST_READ;
            bis_pkg::ST_READ:
            begin
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg == 2'd3)
                    state_next = bis_pkg::ST_DRAIN;
            end
            bis_pkg::ST_DRAIN:
                state_next = bis_pkg::ST_EMIT;
            bis_pkg::ST_EMIT:
            begin
                if (!status.out_busy)
                    state_next = bis_pkg::ST_IDLE;
            end
            default:
                state_next = bis_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.capture   = accept && operation == bis_pkg::OP_QUERY;
        cmd.load_we   = accept && operation == bis_pkg::OP_LOAD;
        cmd.rd_en     = state_reg == bis_pkg::ST_READ;
        cmd.rd_sel    = rd_cnt_reg;
        cmd.acc_clear = state_reg == bis_pkg::ST_BASE;
        cmd.out_load  = (state_reg == bis_pkg::ST_EMIT) && !status.out_busy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bis_pkg::ST_IDLE;
            rd_cnt_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bilinear_image_scaler_core.sv =====
// Scaler top level: config registers, step divider, controller and datapath. A load is
// written as it is accepted. A query's result lands in the output register after two
// arithmetic stages, four neighbour reads through the single memory port, a drain and the
// output load (out of range: no reads or drain); no new request is taken until then, and a
// stalled result holds the core. A scale write stalls input while the divider runs. Reset:
// asynchronous, active low; 1024 x 1024 at scale 256, load counter zero, store not cleared.
`default_nettype none

module bilinear_image_scaler_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input requests
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire bis_pkg::bis_in_t              in_data,
    // results
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output bis_pkg::bis_out_t                  out_data,
    // configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bis_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bis_pkg::SCALE_W-1:0]   cfg_data
);

    logic [bis_pkg::DIM_W-1:0]   width_reg, width_next;
    logic [bis_pkg::DIM_W-1:0]   height_reg, height_next;
    logic [bis_pkg::SCALE_W-1:0] scale_reg, scale_next;
    logic                        cfg_write;
    logic                        scale_start;

    logic [bis_pkg::DIM_W-1:0]   eff_width;
    logic [bis_pkg::DIM_W-1:0]   eff_height;
    logic [bis_pkg::SC_W-1:0]    eff_scale;
    logic [bis_pkg::STEP_W-1:0]  step;
    logic                        step_busy;

    bis_pkg::bis_cmd_t           cmd;
    bis_pkg::bis_status_t        status;

    // Config port is only blocked while the step divider runs.
    assign cfg_ready   = !step_busy;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign scale_start = cfg_write && cfg_index == bis_pkg::CFG_SCALE_Q8;

    // Writes to an index beyond the register list fall through untouched.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        scale_next  = scale_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                bis_pkg::CFG_SOURCE_WIDTH:  width_next  = cfg_data[bis_pkg::DIM_W-1:0];
                bis_pkg::CFG_SOURCE_HEIGHT: height_next = cfg_data[bis_pkg::DIM_W-1:0];
                bis_pkg::CFG_SCALE_Q8:      scale_next  = cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bis_pkg::DIM_W'(bis_pkg::MAX_WIDTH);
            height_reg <= bis_pkg::DIM_W'(bis_pkg::MAX_HEIGHT);
            scale_reg  <= bis_pkg::SCALE_W'(256);
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            scale_reg  <= scale_next;
        end
    end

    // Dimensions clamp to 1..MAX, scale to 51..1280 (about 0.2x..5x).
    assign eff_width  = bis_pkg::clamp_dim(width_reg, bis_pkg::DIM_W'(bis_pkg::MAX_WIDTH));
    assign eff_height = bis_pkg::clamp_dim(height_reg, bis_pkg::DIM_W'(bis_pkg::MAX_HEIGHT));
    assign eff_scale  = bis_pkg::clamp_scale(scale_reg);

    // Step in Q16 source pixels per output pixel, recomputed on each scale write
    // from the clamped write data.
    bis_recip u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scale_start),
        .divisor (bis_pkg::clamp_scale(cfg_data)),
        .busy    (step_busy),
        .step    (step)
    );

    bis_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (in_data.operation),
        .step_busy (step_busy),
        .status    (status),
        .in_stall  (in_stall),
        .cmd       (cmd)
    );

    bis_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (in_data),
        .cmd        (cmd),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .eff_scale  (eff_scale),
        .step       (step),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire
